[src/tpo_pkg.sv]
// Package: widths, beat types and carried side data for the triangle plane orient block.
package tpo_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 15;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int MSB_W   = $clog2(MAG_W);
    localparam int NORM_W  = 30;
    localparam int SQ_W    = 2 * NORM_W;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 31;
    localparam int NUM_W   = NORM_W + NORMAL_FRAC_BITS + 1;
    localparam int QUO_W   = NORMAL_FRAC_BITS + 1;
    localparam int NRM_W   = NORMAL_FRAC_BITS + 1;
    localparam int DOT_W   = CROSS_W + COORD_WIDTH + 2;
    localparam int OPROD_W = NRM_W + COORD_WIDTH;
    localparam int OSUM_W  = OPROD_W + 3;
    localparam int OFF_W   = 32;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] c_x;
        logic signed [15:0] c_y;
        logic signed [15:0] c_z;
        logic signed [15:0] ref_x;
        logic signed [15:0] ref_y;
        logic signed [15:0] ref_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] plane_offset;
        logic               swapped;
        logic               degenerate;
    } result_t;

    // Data that rides along the square root and divide stages.
    typedef struct packed {
        logic [NORM_W-1:0]  m0;
        logic [NORM_W-1:0]  m1;
        logic [NORM_W-1:0]  m2;
        logic               neg0;
        logic               neg1;
        logic               neg2;
        logic               flip;
        logic               degen;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
    } side_t;

endpackage

[src/triangle_plane_orient.sv]
// Top level: pipelined oriented unit plane normal of a triangle.
//
// Usage:
//   item channel (item_valid / item_stall / item) carries one triangle a, b, c
//   plus a target point or reference vector per beat. result channel
//   (result_valid / result_stall / result) returns one beat per item, in order:
//   Q1.15 unit normal, plane offset -(n . a), swapped and degenerate flags.
//   cfg_wr_en / cfg_wr_data write orient_mode (0: flip when C.ref > 0,
//   1: flip when C.ref < 0); write it only while the pipe is empty.
// Throughput: one beat per cycle while the receiver does not stall. The square
//   root is a 31-stage bit-per-stage pipe and the divider a 16-stage
//   restoring pipe.
// Reset (rst_n low, async) empties the pipe and sets orient_mode to 0.
// Stall: the whole pipe freezes while the output register holds a beat the
//   receiver stalls; item_stall then rises in the same cycle, so nothing is
//   lost or repeated.
module triangle_plane_orient
    import tpo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data
);

    logic adv;
    logic mode_reg;
    logic res_valid_reg;
    result_t res_reg;

    // Global advance: the only hold point is the output register.
    assign adv          = !(res_valid_reg && result_stall);
    assign item_stall   = !adv;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage 1: edge vectors ----------------
    logic v1_reg;
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];
    item_t it1_reg;

    // ---------------- stage 2: partial products ----------------
    logic v2_reg;
    logic signed [PROD_W-1:0] p2_reg [6];
    item_t it2_reg;

    // ---------------- stage 3: cross product ----------------
    logic v3_reg;
    logic signed [CROSS_W-1:0] cr3_reg [3];
    item_t it3_reg;

    // ---------------- stage 4: magnitudes, dot partials ----------------
    logic v4_reg;
    logic [MAG_W-1:0] mag4_reg [3];
    logic neg4_reg [3];
    logic degen4_reg;
    logic signed [DOT_W-1:0] dp4_reg [3];
    item_t it4_reg;

    // ---------------- stage 5: orientation, leading one ----------------
    logic v5_reg;
    logic [MAG_W-1:0] mag5_reg [3];
    logic [MSB_W-1:0] msb5_reg;
    side_t sd5_reg;

    logic signed [DOT_W-1:0] dot_sum;
    logic [MAG_W-1:0] mx;
    logic [MSB_W-1:0] msb_next;
    logic flip_next;

    always_comb
    begin
        dot_sum  = dp4_reg[0] + dp4_reg[1] + dp4_reg[2];
        flip_next = mode_reg ? dot_sum[DOT_W-1]
                             : (!dot_sum[DOT_W-1] && (dot_sum != '0));
        mx = mag4_reg[0];
        if (mag4_reg[1] > mx)
        begin
            mx = mag4_reg[1];
        end
        if (mag4_reg[2] > mx)
        begin
            mx = mag4_reg[2];
        end
        msb_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mx[i])
            begin
                msb_next = MSB_W'(i);
            end
        end
    end

    // ---------------- stage 6: scale largest magnitude to [2^29, 2^30) ----------------
    logic v6_reg;
    side_t sd6_reg;
    side_t sd6_next;
    logic [NORM_W-1:0] scaled [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (msb5_reg >= MSB_W'(NORM_W - 1))
            begin
                scaled[i] = NORM_W'(mag5_reg[i] >> (msb5_reg - MSB_W'(NORM_W - 1)));
            end
            else
            begin
                scaled[i] = NORM_W'(64'(mag5_reg[i]) << (MSB_W'(NORM_W - 1) - msb5_reg));
            end
        end
        sd6_next    = sd5_reg;
        sd6_next.m0 = scaled[0];
        sd6_next.m1 = scaled[1];
        sd6_next.m2 = scaled[2];
    end

    // ---------------- stage 7: squares ----------------
    logic v7_reg;
    side_t sd7_reg;
    logic [SQ_W-1:0] sq7_reg [3];

    // ---------------- square root pipe (stage 8 seeds it) ----------------
    logic              sr_v_reg    [0:ROOT_W];
    logic [SUM_W-1:0]  sr_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sr_root_reg [0:ROOT_W];
    side_t             sr_sd_reg   [0:ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            sr_v_reg[0]  <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= item_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            sr_v_reg[0] <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg[0] <= DIFF_W'(item.a_x) - DIFF_W'(item.b_x);
            e1_reg[1] <= DIFF_W'(item.a_y) - DIFF_W'(item.b_y);
            e1_reg[2] <= DIFF_W'(item.a_z) - DIFF_W'(item.b_z);
            e2_reg[0] <= DIFF_W'(item.a_x) - DIFF_W'(item.c_x);
            e2_reg[1] <= DIFF_W'(item.a_y) - DIFF_W'(item.c_y);
            e2_reg[2] <= DIFF_W'(item.a_z) - DIFF_W'(item.c_z);
            it1_reg   <= item;

            p2_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
            p2_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
            p2_reg[2] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
            p2_reg[3] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
            p2_reg[4] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
            p2_reg[5] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);
            it2_reg   <= it1_reg;

            cr3_reg[0] <= CROSS_W'(p2_reg[0]) - CROSS_W'(p2_reg[1]);
            cr3_reg[1] <= CROSS_W'(p2_reg[2]) - CROSS_W'(p2_reg[3]);
            cr3_reg[2] <= CROSS_W'(p2_reg[4]) - CROSS_W'(p2_reg[5]);
            it3_reg    <= it2_reg;

            for (int i = 0; i < 3; i++)
            begin
                mag4_reg[i] <= MAG_W'(cr3_reg[i][CROSS_W-1] ? -cr3_reg[i] : cr3_reg[i]);
                neg4_reg[i] <= cr3_reg[i][CROSS_W-1];
            end
            degen4_reg <= (cr3_reg[0] == '0) && (cr3_reg[1] == '0) && (cr3_reg[2] == '0);
            dp4_reg[0] <= DOT_W'(cr3_reg[0]) * DOT_W'(it3_reg.ref_x);
            dp4_reg[1] <= DOT_W'(cr3_reg[1]) * DOT_W'(it3_reg.ref_y);
            dp4_reg[2] <= DOT_W'(cr3_reg[2]) * DOT_W'(it3_reg.ref_z);
            it4_reg    <= it3_reg;

            mag5_reg      <= mag4_reg;
            msb5_reg      <= msb_next;
            sd5_reg.m0    <= '0;
            sd5_reg.m1    <= '0;
            sd5_reg.m2    <= '0;
            sd5_reg.neg0  <= neg4_reg[0];
            sd5_reg.neg1  <= neg4_reg[1];
            sd5_reg.neg2  <= neg4_reg[2];
            sd5_reg.flip  <= flip_next && !degen4_reg;
            sd5_reg.degen <= degen4_reg;
            sd5_reg.a_x   <= it4_reg.a_x;
            sd5_reg.a_y   <= it4_reg.a_y;
            sd5_reg.a_z   <= it4_reg.a_z;

            sd6_reg <= sd6_next;

            sd7_reg    <= sd6_reg;
            sq7_reg[0] <= SQ_W'(sd6_reg.m0) * SQ_W'(sd6_reg.m0);
            sq7_reg[1] <= SQ_W'(sd6_reg.m1) * SQ_W'(sd6_reg.m1);
            sq7_reg[2] <= SQ_W'(sd6_reg.m2) * SQ_W'(sd6_reg.m2);

            sr_rem_reg[0]  <= SUM_W'(sq7_reg[0]) + SUM_W'(sq7_reg[1]) + SUM_W'(sq7_reg[2]);
            sr_root_reg[0] <= '0;
            sr_sd_reg[0]   <= sd7_reg;
        end
    end

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [SUM_W-1:0] trial;

        assign trial = (SUM_W'(sr_root_reg[k]) << (B + 1)) | (SUM_W'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sr_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sr_v_reg[k+1] <= sr_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sr_sd_reg[k+1] <= sr_sd_reg[k];
                if (sr_rem_reg[k] >= trial)
                begin
                    sr_rem_reg[k+1]  <= sr_rem_reg[k] - trial;
                    sr_root_reg[k+1] <= sr_root_reg[k] | (ROOT_W'(1) << B);
                end
                else
                begin
                    sr_rem_reg[k+1]  <= sr_rem_reg[k];
                    sr_root_reg[k+1] <= sr_root_reg[k];
                end
            end
        end
    end

    // ---------------- divider pipe: q = (m << F + L/2) / L ----------------
    logic              dv_v_reg   [0:QUO_W];
    logic [NUM_W-1:0]  dv_rem_reg [0:QUO_W][3];
    logic [QUO_W-1:0]  dv_q_reg   [0:QUO_W][3];
    logic [ROOT_W-1:0] dv_len_reg [0:QUO_W];
    side_t             dv_sd_reg  [0:QUO_W];

    logic [ROOT_W-1:0] len;
    assign len = sr_root_reg[ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= sr_v_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0][0] <= (NUM_W'(sr_sd_reg[ROOT_W].m0) << NORMAL_FRAC_BITS)
                                + NUM_W'(len >> 1);
            dv_rem_reg[0][1] <= (NUM_W'(sr_sd_reg[ROOT_W].m1) << NORMAL_FRAC_BITS)
                                + NUM_W'(len >> 1);
            dv_rem_reg[0][2] <= (NUM_W'(sr_sd_reg[ROOT_W].m2) << NORMAL_FRAC_BITS)
                                + NUM_W'(len >> 1);
            for (int i = 0; i < 3; i++)
            begin
                dv_q_reg[0][i] <= '0;
            end
            dv_len_reg[0] <= len;
            dv_sd_reg[0]  <= sr_sd_reg[ROOT_W];
        end
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int K = QUO_W - 1 - j;
        logic [NUM_W-1:0] dsub;

        assign dsub = NUM_W'(dv_len_reg[j]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_sd_reg[j+1]  <= dv_sd_reg[j];
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem_reg[j][i] >= dsub)
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - dsub;
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i] | (QUO_W'(1) << K);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i];
                    end
                end
            end
        end
    end

    // ---------------- saturate, sign, flip ----------------
    localparam logic [QUO_W-1:0] QMAX = QUO_W'((1 << NORMAL_FRAC_BITS) - 1);

    logic v_n_reg;
    logic signed [NRM_W-1:0] nrm_reg [3];
    side_t sd_n_reg;
    logic neg_lane [3];

    assign neg_lane[0] = dv_sd_reg[QUO_W].neg0 ^ dv_sd_reg[QUO_W].flip;
    assign neg_lane[1] = dv_sd_reg[QUO_W].neg1 ^ dv_sd_reg[QUO_W].flip;
    assign neg_lane[2] = dv_sd_reg[QUO_W].neg2 ^ dv_sd_reg[QUO_W].flip;

    // ---------------- offset products, final sum ----------------
    logic v_o_reg;
    logic signed [OPROD_W-1:0] op_reg [3];
    side_t sd_o_reg;
    logic signed [NRM_W-1:0] nrm_o_reg [3];

    logic signed [OSUM_W-1:0] osum;
    logic signed [OSUM_W-1:0] off;
    logic signed [OFF_W-1:0]  off_sat;

    always_comb
    begin
        osum = OSUM_W'(op_reg[0]) + OSUM_W'(op_reg[1]) + OSUM_W'(op_reg[2]);
        off  = -osum;
        if (off > OSUM_W'(32'sh7FFF_FFFF))
        begin
            off_sat = 32'sh7FFF_FFFF;
        end
        else if (off < -OSUM_W'(33'sh0_8000_0000))
        begin
            off_sat = 32'sh8000_0000;
        end
        else
        begin
            off_sat = OFF_W'(off);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_n_reg       <= 1'b0;
            v_o_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_n_reg       <= dv_v_reg[QUO_W];
            v_o_reg       <= v_n_reg;
            res_valid_reg <= v_o_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [QUO_W-1:0] qs;
                qs = (dv_q_reg[QUO_W][i] > QMAX) ? QMAX : dv_q_reg[QUO_W][i];
                nrm_reg[i] <= neg_lane[i] ? -$signed(NRM_W'(qs)) : $signed(NRM_W'(qs));
            end
            sd_n_reg <= dv_sd_reg[QUO_W];

            op_reg[0] <= OPROD_W'(nrm_reg[0]) * OPROD_W'(sd_n_reg.a_x);
            op_reg[1] <= OPROD_W'(nrm_reg[1]) * OPROD_W'(sd_n_reg.a_y);
            op_reg[2] <= OPROD_W'(nrm_reg[2]) * OPROD_W'(sd_n_reg.a_z);
            nrm_o_reg <= nrm_reg;
            sd_o_reg  <= sd_n_reg;

            // degenerate triangle: everything zero but the flag
            if (sd_o_reg.degen)
            begin
                res_reg.normal_x     <= '0;
                res_reg.normal_y     <= '0;
                res_reg.normal_z     <= '0;
                res_reg.plane_offset <= '0;
                res_reg.swapped      <= 1'b0;
                res_reg.degenerate   <= 1'b1;
            end
            else
            begin
                res_reg.normal_x     <= 16'(nrm_o_reg[0]);
                res_reg.normal_y     <= 16'(nrm_o_reg[1]);
                res_reg.normal_z     <= 16'(nrm_o_reg[2]);
                res_reg.plane_offset <= off_sat;
                res_reg.swapped      <= sd_o_reg.flip;
                res_reg.degenerate   <= 1'b0;
            end
        end
    end

endmodule
